@@ design/ghn_pkg.sv @@
// ----------------------------------------------------------------------------
// Gray histogram normaliser package
// Shared sizes, command codes, word types and helper functions.
// ----------------------------------------------------------------------------
package ghn_pkg;

  // Histogram geometry.
  localparam int BINS        = 256;
  localparam int COUNT_WIDTH = 24;
  localparam int BIN_AW      = (BINS > 1) ? $clog2(BINS) : 1;

  // Field widths of the words on the ports.
  localparam int CMD_W     = 2;
  localparam int SAMPLE_W  = 8;
  localparam int OUT_CW    = 24;
  localparam int PROB_W    = 17;
  localparam int FRAC_W    = 16;
  localparam int ONE_FIXED = 65536;

  // Divider geometry: the dividend is the count shifted up by the fraction.
  localparam int DIV_W   = COUNT_WIDTH + FRAC_W;
  localparam int DIV_CNT = $clog2(DIV_W + 1);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] query_bin;
  } in_word_t;

  typedef struct packed {
    logic [OUT_CW-1:0] bin_count;
    logic [PROB_W-1:0] probability;
    logic              empty_flag;
  } out_word_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DIV,
    ST_DONE
  } state_t;

  // Control to and status from the shared divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Saturating increment of a counter.
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Fit a counter value into the bin_count field of the result word.
  function automatic logic [OUT_CW-1:0] to_out_count(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+OUT_CW-1:0] w;
    w = {{OUT_CW{1'b0}}, v};
    return w[OUT_CW-1:0];
  endfunction

endpackage

@@ design/ghn_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ghn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ghn_divider.sv @@
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Divides a bin count, scaled by 2^16, by the sample total, one quotient bit
// per cycle through a single shared subtract and compare.
// ----------------------------------------------------------------------------
module ghn_divider
  import ghn_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  div_ctrl_t              ctrl,
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [COUNT_WIDTH-1:0] divisor,
  output div_stat_t              stat,
  output logic [DIV_W-1:0]       quotient
);

  logic [DIV_W-1:0]       dvd_r, dvd_nxt;
  logic [DIV_W-1:0]       quo_r, quo_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] dsr_r, dsr_nxt;
  logic [DIV_CNT-1:0]     cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [COUNT_WIDTH:0]   trial;
  logic [COUNT_WIDTH:0]   diff;
  logic                   fits;

  // The shared unit: shift in one dividend bit, compare and subtract.
  assign trial = {rem_r, dvd_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctrl.start) begin
      dvd_nxt  = {count, {FRAC_W{1'b0}}};
      quo_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      rem_nxt = fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

@@ design/gray_histogram_normalizer.sv @@
// ----------------------------------------------------------------------------
// Gray histogram normaliser
// 256-bin histogram of gray samples with normalised bin probabilities.
// ----------------------------------------------------------------------------
// Each input word is one command and yields one result word. An add or a clear
// passes from acceptance through the look-up and done states to a registered
// result; a read of a non-empty histogram also waits in the restoring divider,
// which makes one of the 40 quotient bits of count * 2^16 / total per cycle.
// Bin counts live in a RAM with one registered read port; a valid bit per bin,
// cleared by reset and by the clear command, makes an unwritten bin read as
// zero, so there is no clearing pass. The input is taken only while the
// sequencer is idle, and a finished result waits in the output register while
// the next word is accepted.
// ----------------------------------------------------------------------------
module gray_histogram_normalizer
  import ghn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  state_t                 state_r, state_nxt;
  logic [CMD_W-1:0]       cmd_r;
  logic [SAMPLE_W-1:0]    addr_r;
  logic                   ent_valid_r;
  logic [BINS-1:0]        valid_r, valid_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  out_word_t              res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_data_r, out_data_nxt;

  logic                   accept;
  logic [SAMPLE_W-1:0]    in_addr;
  logic                   in_range;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] entry;
  logic                   ram_we;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  div_ctrl_t              div_ctrl;
  div_stat_t              div_stat;
  logic [DIV_W-1:0]       quotient;
  logic [PROB_W-1:0]      prob_clamped;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_addr  = (in_data.command == CMD_ADD) ? in_data.sample : in_data.query_bin;
  assign in_range = ({1'b0, addr_r} < (SAMPLE_W + 1)'(BINS));
  assign entry    = ent_valid_r ? rd_data : '0;

  // Bin count store.
  ghn_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r[BIN_AW-1:0]),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_addr[BIN_AW-1:0]),
    .rdata (rd_data)
  );

  // Shared divider for the probability; it captures the bin count at start.
  ghn_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .count    (entry),
    .divisor  (total_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // The probability never exceeds one; hold it there all the same.
  assign prob_clamped = (quotient > DIV_W'(ONE_FIXED)) ? PROB_W'(ONE_FIXED)
                                                        : quotient[PROB_W-1:0];

  // Sequencer: next state, store updates and result word.
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    total_nxt     = total_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_wdata     = sat_inc(entry);
    div_ctrl      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        res_nxt   = '0;
        state_nxt = ST_DONE;
        unique case (cmd_r)
          CMD_ADD: begin
            if (in_range) begin
              ram_we                     = 1'b1;
              valid_nxt[addr_r[BIN_AW-1:0]] = 1'b1;
              total_nxt                  = sat_inc(total_r);
            end
          end
          CMD_READ: begin
            if (total_r == '0) begin
              res_nxt.empty_flag = 1'b1;
            end else if (in_range) begin
              res_nxt.bin_count = to_out_count(entry);
              div_ctrl.start    = 1'b1;
              state_nxt         = ST_DIV;
            end
          end
          CMD_CLEAR: begin
            valid_nxt = '0;
            total_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_nxt.probability = prob_clamped;
          state_nxt           = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_data.command;
      addr_r      <= in_addr;
      ent_valid_r <= valid_r[in_addr[BIN_AW-1:0]];
    end
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/ghn_checker.sv @@
// ----------------------------------------------------------------------------
// Gray histogram normaliser checker
// Port-level assertions on the result word and the input handshake.
// ----------------------------------------------------------------------------
module ghn_checker
  import ghn_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  // After a word is taken the block works on it before taking another.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // An empty histogram reports neither a count nor a probability.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_flag |->
      (out_data.probability == '0) && (out_data.bin_count == '0))
    else $error("empty result carries a count or probability");

  // The probability never exceeds one.
  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.probability <= PROB_W'(ONE_FIXED)))
    else $error("probability above one");

endmodule

bind gray_histogram_normalizer ghn_checker u_ghn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
